FILE: rtl/imu_sample_correct_filter_assert.svh
// Assertion macros for the IMU sample correction and filter block.
// Used by modules that clock on i_clk and reset on i_rst_n.
`ifndef IMU_SAMPLE_CORRECT_FILTER_ASSERT_SVH
`define IMU_SAMPLE_CORRECT_FILTER_ASSERT_SVH

// Same-cycle implication.
`define SCF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/imu_scf_pkg.sv
// Shared types and constants of the IMU sample correction and filter block.
// No dependencies.
package imu_scf_pkg;

    localparam int RAW_W   = 16;
    localparam int BIAS_W  = 20;
    localparam int COEF_W  = 18;
    localparam int V_W     = 43;
    localparam int V_LO_W  = 22;
    localparam int ACC_W   = 64;
    localparam int SMOOTH_W = 17;

    localparam logic signed [22:0] MAG_GAIN  = 23'sd2726298;
    localparam logic signed [22:0] UT16_GAIN = 23'sd2684355;
    localparam logic [16:0] Q_ONE = 17'd65536;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    localparam logic [2:0] REG_ACCEL_BIAS   = 3'd0;
    localparam logic [2:0] REG_MAG_BIAS     = 3'd1;
    localparam logic [2:0] REG_ROW_X        = 3'd2;
    localparam logic [2:0] REG_ROW_Y        = 3'd3;
    localparam logic [2:0] REG_ROW_Z        = 3'd4;
    localparam logic [2:0] REG_ACCEL_SMOOTH = 3'd5;
    localparam logic [2:0] REG_MAG_SMOOTH   = 3'd6;

    localparam logic [53:0] ROW_X_RST = 54'd65536;
    localparam logic [53:0] ROW_Y_RST = 54'd17179869184;
    localparam logic [53:0] ROW_Z_RST = 54'd4503599627370496;
    localparam logic [16:0] SMOOTH_RST = 17'd6554;

    typedef struct packed {
        logic prod;
        logic diff;
        logic mul;
        logic mac;
        logic rnd;
        logic fmul;
        logic fupd;
        logic is_mag;
        logic tout;
        logic primed;
    } t_lane_ctl;

endpackage

FILE: rtl/imu_scf_if.sv
// Sample and result channels of the IMU sample correction and filter block.
// No dependencies.
interface imu_scf_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
    logic               timed_out;

    modport source (output valid, cmd, raw_x, raw_y, raw_z, timed_out, input ready);
    modport sink   (input valid, cmd, raw_x, raw_y, raw_z, timed_out, output ready);
endinterface

interface imu_scf_out_if;
    logic               valid;
    logic               ready;
    logic               sensor;
    logic signed [31:0] corrected_x;
    logic signed [31:0] corrected_y;
    logic signed [31:0] corrected_z;
    logic signed [31:0] smoothed_x;
    logic signed [31:0] smoothed_y;
    logic signed [31:0] smoothed_z;
    logic               timeout_seen;

    modport source (output valid, sensor, corrected_x, corrected_y, corrected_z,
                    smoothed_x, smoothed_y, smoothed_z, timeout_seen, input ready);
    modport sink   (input valid, sensor, corrected_x, corrected_y, corrected_z,
                    smoothed_x, smoothed_y, smoothed_z, timeout_seen, output ready);
endinterface

FILE: rtl/imu_scf_lane.sv
// One axis lane: scale, bias, matrix row product, rounding and low-pass filter.
// Depends on imu_scf_pkg.
module imu_scf_lane #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  imu_scf_pkg::t_lane_ctl    i_ctl,
    input  logic signed [15:0]        i_raw,
    input  logic                      i_negate,
    input  logic signed [19:0]        i_accel_bias,
    input  logic signed [19:0]        i_mag_offset,
    input  logic signed [17:0]        i_coef,
    input  logic signed [42:0]        i_vk,
    input  logic [16:0]               i_smooth,
    output logic signed [42:0]        o_v,
    output logic signed [31:0]        o_corr,
    output logic signed [31:0]        o_smoothed
);

    localparam int SHIFT = 48 - FRACTION_BITS;

    logic signed [16:0] w_raw17;
    logic signed [11:0] w_a12;
    logic signed [12:0] w_a13;
    logic signed [63:0] w_acc_accel;
    logic signed [63:0] w_rnd;
    logic signed [63:0] w_shr;
    logic signed [31:0] w_sat;
    logic [16:0]        w_wt;
    logic [16:0]        w_wt_inv;
    logic signed [31:0] w_fsel;
    logic signed [51:0] w_fsum;
    logic signed [31:0] w_fnew;

    logic signed [39:0] r_pa;
    logic signed [42:0] r_pb;
    logic signed [42:0] r_v;
    logic signed [40:0] r_plo;
    logic signed [38:0] r_phi;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_corr;
    logic signed [49:0] r_fa;
    logic signed [49:0] r_fb;
    logic signed [31:0] r_smoothed;
    logic signed [31:0] r_filt_acc;
    logic signed [31:0] r_filt_mag;

    assign w_raw17 = i_negate ? -17'(i_raw) : 17'(i_raw);
    assign w_a12   = 12'(i_raw >>> 4);
    assign w_a13   = i_negate ? -13'(w_a12) : 13'(w_a12);
    assign w_acc_accel = (64'(w_a13) <<< 38) - (64'(i_accel_bias) <<< 32);

    assign w_rnd = r_acc + (64'sd1 <<< (SHIFT - 1));
    assign w_shr = w_rnd >>> SHIFT;

    always_comb begin
        if (w_shr > imu_scf_pkg::SAT_MAX) begin
            w_sat = 32'(imu_scf_pkg::SAT_MAX);
        end else if (w_shr < imu_scf_pkg::SAT_MIN) begin
            w_sat = 32'(imu_scf_pkg::SAT_MIN);
        end else begin
            w_sat = 32'(w_shr);
        end
    end

    assign w_wt     = (i_smooth > imu_scf_pkg::Q_ONE) ? imu_scf_pkg::Q_ONE : i_smooth;
    assign w_wt_inv = imu_scf_pkg::Q_ONE - w_wt;
    assign w_fsel   = i_ctl.is_mag ? r_filt_mag : r_filt_acc;
    assign w_fsum   = 52'(r_fa) + 52'(r_fb) + 52'sd32768;
    assign w_fnew   = i_ctl.primed ? $signed(w_fsum[47:16]) : r_corr;

    always_ff @(posedge i_clk) begin
        if (i_ctl.prod) begin
            r_pa <= 40'(w_raw17) * 40'(imu_scf_pkg::MAG_GAIN);
            r_pb <= 43'(i_mag_offset) * 43'(imu_scf_pkg::UT16_GAIN);
            r_acc <= i_ctl.is_mag ? 64'sd0 : w_acc_accel;
        end else if (i_ctl.mac) begin
            r_acc <= r_acc + (64'(r_phi) <<< imu_scf_pkg::V_LO_W) + 64'(r_plo);
        end
        if (i_ctl.diff) begin
            r_v <= 43'(r_pa) - r_pb;
        end
        if (i_ctl.mul) begin
            r_plo <= 41'(i_coef) * 41'($signed({1'b0, i_vk[21:0]}));
            r_phi <= 39'(i_coef) * 39'($signed(i_vk[42:22]));
        end
        if (i_ctl.rnd) begin
            r_corr <= i_ctl.tout ? 32'sd0 : w_sat;
        end
        if (i_ctl.fmul) begin
            r_fa <= 50'(r_corr) * 50'($signed({1'b0, w_wt}));
            r_fb <= 50'(w_fsel) * 50'($signed({1'b0, w_wt_inv}));
        end
        if (i_ctl.fupd) begin
            r_smoothed <= w_fnew;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt_acc <= '0;
            r_filt_mag <= '0;
        end else if (i_ctl.fupd) begin
            if (i_ctl.is_mag) begin
                r_filt_mag <= w_fnew;
            end else begin
                r_filt_acc <= w_fnew;
            end
        end
    end

    assign o_v        = r_v;
    assign o_corr     = r_corr;
    assign o_smoothed = r_smoothed;

endmodule

FILE: rtl/imu_scf_merge.sv
// Merging stage: gathers the three lane results into the result word register.
// Depends on imu_scf_out_if.
module imu_scf_merge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_sensor,
    input  logic               i_flag,
    input  logic signed [31:0] i_corr [3],
    input  logic signed [31:0] i_smoothed [3],
    output logic               o_room,
    imu_scf_out_if.source      o_result
);

    logic               r_valid;
    logic               r_sensor;
    logic               r_flag;
    logic signed [31:0] r_corr [3];
    logic signed [31:0] r_smoothed [3];

    assign o_room = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_sensor   <= i_sensor;
            r_flag     <= i_flag;
            r_corr     <= i_corr;
            r_smoothed <= i_smoothed;
        end
    end

    assign o_result.valid        = r_valid;
    assign o_result.sensor       = r_sensor;
    assign o_result.timeout_seen = r_flag;
    assign o_result.corrected_x  = r_corr[0];
    assign o_result.corrected_y  = r_corr[1];
    assign o_result.corrected_z  = r_corr[2];
    assign o_result.smoothed_x   = r_smoothed[0];
    assign o_result.smoothed_y   = r_smoothed[1];
    assign o_result.smoothed_z   = r_smoothed[2];

endmodule

FILE: rtl/imu_sample_correct_filter.sv
// IMU sample correction and filter: one accelerometer or magnetometer sample in,
// one word out with corrected and low-pass filtered Q.FRACTION_BITS axes. An
// accelerometer sample occupies the block from acceptance until its word moves
// to the result register; a magnetometer sample also makes the three-column matrix
// pass through each lane's single multiplier pair, and both pass the filter
// multiply. The result register lets a new sample be taken while the last word
// waits. Registers are written over the APB port at 8*index.
// Depends on imu_scf_pkg, imu_scf_if, imu_scf_lane, imu_scf_merge.
`include "imu_sample_correct_filter_assert.svh"

module imu_sample_correct_filter #(
    parameter int FRACTION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    imu_scf_in_if.sink    i_sample,
    imu_scf_out_if.source o_result
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_PROD = 11'b00000000010,
        S_DIFF = 11'b00000000100,
        S_MUL0 = 11'b00000001000,
        S_MUL1 = 11'b00000010000,
        S_MUL2 = 11'b00000100000,
        S_MACL = 11'b00001000000,
        S_RND  = 11'b00010000000,
        S_FMUL = 11'b00100000000,
        S_FUPD = 11'b01000000000,
        S_DONE = 11'b10000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [59:0]        r_accel_bias;
    logic [59:0]        r_mag_offset;
    logic [53:0]        r_row [3];
    logic [16:0]        r_acc_smooth;
    logic [16:0]        r_mag_smooth;

    logic               r_cmd;
    logic               r_tout;
    logic signed [15:0] r_raw [3];
    logic               r_acc_primed;
    logic               r_mag_primed;
    logic               r_acc_tflag;
    logic               r_mag_tflag;

    logic               w_wr;
    logic [2:0]         w_idx;
    logic               w_in_acc;
    logic               w_room;
    logic               w_push;
    logic [1:0]         w_k;
    logic signed [42:0] w_v [3];
    logic signed [42:0] w_vk;
    logic signed [17:0] w_coef [3];
    logic signed [31:0] w_corr [3];
    logic signed [31:0] w_smoothed [3];
    imu_scf_pkg::t_lane_ctl w_ctl;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_bias <= '0;
            r_mag_offset <= '0;
            r_row[0]     <= imu_scf_pkg::ROW_X_RST;
            r_row[1]     <= imu_scf_pkg::ROW_Y_RST;
            r_row[2]     <= imu_scf_pkg::ROW_Z_RST;
            r_acc_smooth <= imu_scf_pkg::SMOOTH_RST;
            r_mag_smooth <= imu_scf_pkg::SMOOTH_RST;
        end else if (w_wr) begin
            case (w_idx)
                imu_scf_pkg::REG_ACCEL_BIAS:   r_accel_bias <= pwdata[59:0];
                imu_scf_pkg::REG_MAG_BIAS:     r_mag_offset <= pwdata[59:0];
                imu_scf_pkg::REG_ROW_X:        r_row[0]     <= pwdata[53:0];
                imu_scf_pkg::REG_ROW_Y:        r_row[1]     <= pwdata[53:0];
                imu_scf_pkg::REG_ROW_Z:        r_row[2]     <= pwdata[53:0];
                imu_scf_pkg::REG_ACCEL_SMOOTH: r_acc_smooth <= pwdata[16:0];
                imu_scf_pkg::REG_MAG_SMOOTH:   r_mag_smooth <= pwdata[16:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            imu_scf_pkg::REG_ACCEL_BIAS:   prdata = 64'(r_accel_bias);
            imu_scf_pkg::REG_MAG_BIAS:     prdata = 64'(r_mag_offset);
            imu_scf_pkg::REG_ROW_X:        prdata = 64'(r_row[0]);
            imu_scf_pkg::REG_ROW_Y:        prdata = 64'(r_row[1]);
            imu_scf_pkg::REG_ROW_Z:        prdata = 64'(r_row[2]);
            imu_scf_pkg::REG_ACCEL_SMOOTH: prdata = 64'(r_acc_smooth);
            imu_scf_pkg::REG_MAG_SMOOTH:   prdata = 64'(r_mag_smooth);
            default:                       prdata = '0;
        endcase
    end

    assign i_sample.ready = (r_state == S_IDLE);
    assign w_in_acc = i_sample.valid && i_sample.ready;
    assign w_push   = (r_state == S_DONE) && w_room;

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = w_in_acc ? S_PROD : S_IDLE;
            S_PROD:  n_state = r_cmd ? S_DIFF : S_RND;
            S_DIFF:  n_state = S_MUL0;
            S_MUL0:  n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_MACL;
            S_MACL:  n_state = S_RND;
            S_RND:   n_state = S_FMUL;
            S_FMUL:  n_state = S_FUPD;
            S_FUPD:  n_state = S_DONE;
            S_DONE:  n_state = w_room ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_acc_primed <= 1'b0;
            r_mag_primed <= 1'b0;
            r_acc_tflag  <= 1'b0;
            r_mag_tflag  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc && i_sample.timed_out) begin
                if (i_sample.cmd) begin
                    r_mag_tflag <= 1'b1;
                end else begin
                    r_acc_tflag <= 1'b1;
                end
            end
            if (r_state == S_FUPD) begin
                if (r_cmd) begin
                    r_mag_primed <= 1'b1;
                end else begin
                    r_acc_primed <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd    <= i_sample.cmd;
            r_tout   <= i_sample.timed_out;
            r_raw[0] <= i_sample.raw_x;
            r_raw[1] <= i_sample.raw_y;
            r_raw[2] <= i_sample.raw_z;
        end
    end

    always_comb begin
        w_ctl        = '0;
        w_ctl.prod   = (r_state == S_PROD);
        w_ctl.diff   = (r_state == S_DIFF);
        w_ctl.mul    = (r_state == S_MUL0) || (r_state == S_MUL1) || (r_state == S_MUL2);
        w_ctl.mac    = (r_state == S_MUL1) || (r_state == S_MUL2) || (r_state == S_MACL);
        w_ctl.rnd    = (r_state == S_RND);
        w_ctl.fmul   = (r_state == S_FMUL);
        w_ctl.fupd   = (r_state == S_FUPD);
        w_ctl.is_mag = r_cmd;
        w_ctl.tout   = r_tout;
        w_ctl.primed = r_cmd ? r_mag_primed : r_acc_primed;
    end

    always_comb begin
        case (r_state)
            S_MUL1:  w_k = 2'd1;
            S_MUL2:  w_k = 2'd2;
            default: w_k = 2'd0;
        endcase
    end

    always_comb begin
        case (w_k)
            2'd1: begin
                w_vk = w_v[1];
                for (int j = 0; j < 3; j++) begin
                    w_coef[j] = $signed(r_row[j][35:18]);
                end
            end
            2'd2: begin
                w_vk = w_v[2];
                for (int j = 0; j < 3; j++) begin
                    w_coef[j] = $signed(r_row[j][53:36]);
                end
            end
            default: begin
                w_vk = w_v[0];
                for (int j = 0; j < 3; j++) begin
                    w_coef[j] = $signed(r_row[j][17:0]);
                end
            end
        endcase
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        imu_scf_lane #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_raw        (r_raw[g]),
            .i_negate     (1'(g != 0)),
            .i_accel_bias ($signed(r_accel_bias[20*g +: 20])),
            .i_mag_offset ($signed(r_mag_offset[20*g +: 20])),
            .i_coef       (w_coef[g]),
            .i_vk         (w_vk),
            .i_smooth     (r_cmd ? r_mag_smooth : r_acc_smooth),
            .o_v          (w_v[g]),
            .o_corr       (w_corr[g]),
            .o_smoothed   (w_smoothed[g])
        );
    end

    imu_scf_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_sensor   (r_cmd),
        .i_flag     (r_cmd ? r_mag_tflag : r_acc_tflag),
        .i_corr     (w_corr),
        .i_smoothed (w_smoothed),
        .o_room     (w_room),
        .o_result   (o_result)
    );

    `SCF_ASSERT_NEXT(a_push_shows_word, w_push, o_result.valid, "pushed word not shown")
    `SCF_ASSERT_NEXT(a_mag_tout_flag, w_in_acc && i_sample.timed_out && i_sample.cmd, r_mag_tflag, "mag timeout flag not set")
    `SCF_ASSERT_SAME(a_done_primed, r_state == S_DONE, (r_cmd ? r_mag_primed : r_acc_primed), "sensor not primed at done")

endmodule

FILE: tb/tb_imu_sample_correct_filter.sv
// Testbench for imu_sample_correct_filter: drives samples and APB register writes,
// predicts corrected and smoothed vectors and checks every result word in order.
// Depends on imu_scf_pkg, imu_scf_if and the block itself.
`timescale 1ns / 1ps

module tb_imu_sample_correct_filter;

    typedef struct {
        logic        sensor;
        logic [31:0] corr [3];
        logic [31:0] smth [3];
        logic        tflag;
    } t_vec_word;

    class vec_scoreboard;
        logic [59:0] accel_bias, mag_offset;
        logic [53:0] row [3];
        logic [16:0] a_smooth, m_smooth;
        logic signed [31:0] a_filt [3], m_filt [3];
        bit a_primed, m_primed, a_tflag, m_tflag;
        t_vec_word pending [$];
        int errors, n_words;

        function new();
            accel_bias = 0; mag_offset = 0;
            row[0] = imu_scf_pkg::ROW_X_RST;
            row[1] = imu_scf_pkg::ROW_Y_RST;
            row[2] = imu_scf_pkg::ROW_Z_RST;
            a_smooth = imu_scf_pkg::SMOOTH_RST; m_smooth = imu_scf_pkg::SMOOTH_RST;
            for (int i = 0; i < 3; i++) begin
                a_filt[i] = 0; m_filt[i] = 0;
            end
            a_primed = 0; m_primed = 0; a_tflag = 0; m_tflag = 0;
            errors = 0; n_words = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] v);
            case (idx)
                imu_scf_pkg::REG_ACCEL_BIAS: accel_bias = v[59:0];
                imu_scf_pkg::REG_MAG_BIAS: mag_offset = v[59:0];
                imu_scf_pkg::REG_ROW_X: row[0] = v[53:0];
                imu_scf_pkg::REG_ROW_Y: row[1] = v[53:0];
                imu_scf_pkg::REG_ROW_Z: row[2] = v[53:0];
                imu_scf_pkg::REG_ACCEL_SMOOTH: a_smooth = v[16:0];
                imu_scf_pkg::REG_MAG_SMOOTH: m_smooth = v[16:0];
                default: ;
            endcase
        endfunction

        function logic signed [31:0] round_sat(logic signed [63:0] x);
            logic signed [63:0] r;
            r = (x + 64'sd2147483648) >>> 32;
            if (r > imu_scf_pkg::SAT_MAX) return 32'h7fffffff;
            if (r < imu_scf_pkg::SAT_MIN) return 32'h80000000;
            return r[31:0];
        endfunction

        function logic signed [31:0] lowpass(logic signed [31:0] r, logic signed [31:0] f,
                                             logic [16:0] w);
            logic signed [63:0] wt, acc;
            wt = (w > 17'd65536) ? 64'sd65536 : $signed({47'd0, w});
            acc = 64'(r) * wt + 64'(f) * (64'sd65536 - wt) + 64'sd32768;
            return 32'(acc >>> 16);
        endfunction

        function void note_sample(logic cmd, logic signed [15:0] rx, logic signed [15:0] ry,
                                  logic signed [15:0] rz, logic tout);
            t_vec_word wd;
            logic signed [63:0] raw [3], v [3], a, b, c, acc;
            logic signed [31:0] corr [3];
            logic [16:0] w;
            raw[0] = rx; raw[1] = ry; raw[2] = rz;
            for (int i = 0; i < 3; i++) begin
                if (tout) corr[i] = 0;
                else if (!cmd) begin
                    a = raw[i] >>> 4;
                    if (i > 0) a = -a;
                    b = $signed(accel_bias[20*i +: 20]);
                    corr[i] = round_sat(a * (64'sd1 <<< 38) - b * (64'sd1 <<< 32));
                end
            end
            if (cmd && !tout) begin
                for (int i = 0; i < 3; i++) begin
                    a = (i > 0) ? -raw[i] : raw[i];
                    b = $signed(mag_offset[20*i +: 20]);
                    v[i] = a * 64'sd2726298 - b * 64'sd2684355;
                end
                for (int j = 0; j < 3; j++) begin
                    acc = 0;
                    for (int i = 0; i < 3; i++) begin
                        c = $signed(row[j][18*i +: 18]);
                        acc += c * v[i];
                    end
                    corr[j] = round_sat(acc);
                end
            end
            if (tout) begin
                if (cmd) m_tflag = 1; else a_tflag = 1;
            end
            w = cmd ? m_smooth : a_smooth;
            for (int i = 0; i < 3; i++) begin
                if (cmd) m_filt[i] = m_primed ? lowpass(corr[i], m_filt[i], w) : corr[i];
                else a_filt[i] = a_primed ? lowpass(corr[i], a_filt[i], w) : corr[i];
                wd.corr[i] = corr[i];
                wd.smth[i] = cmd ? m_filt[i] : a_filt[i];
            end
            if (cmd) m_primed = 1; else a_primed = 1;
            wd.sensor = cmd;
            wd.tflag = cmd ? m_tflag : a_tflag;
            pending.push_back(wd);
        endfunction

        function void check_word(t_vec_word got);
            t_vec_word exp_w;
            n_words++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word sensor=%0d", $realtime, got.sensor);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.sensor !== exp_w.sensor || got.tflag !== exp_w.tflag) begin
                $display("%0t: sensor/flag exp %0d/%0d got %0d/%0d", $realtime,
                         exp_w.sensor, exp_w.tflag, got.sensor, got.tflag);
                errors++;
            end
            for (int i = 0; i < 3; i++) begin
                if (got.corr[i] !== exp_w.corr[i]) begin
                    $display("%0t: corrected[%0d] exp %h got %h", $realtime, i,
                             exp_w.corr[i], got.corr[i]);
                    errors++;
                end
                if (got.smth[i] !== exp_w.smth[i]) begin
                    $display("%0t: smoothed[%0d] exp %h got %h", $realtime, i,
                             exp_w.smth[i], got.smth[i]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [5:0]  paddr = 0;
    logic [63:0] pwdata = 0;
    logic [63:0] prdata;
    logic        pready;

    imu_scf_in_if  smp_if ();
    imu_scf_out_if res_if ();

    imu_sample_correct_filter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_sample(smp_if.sink), .o_result(res_if.source)
    );

    vec_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_sent = 0;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    initial begin
        smp_if.valid = 0; smp_if.cmd = 0; smp_if.raw_x = 0; smp_if.raw_y = 0;
        smp_if.raw_z = 0; smp_if.timed_out = 0;
        res_if.ready = 0;
    end

    always @(posedge i_clk) begin
        t_vec_word got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.sensor = res_if.sensor;
            got.corr[0] = res_if.corrected_x;
            got.corr[1] = res_if.corrected_y;
            got.corr[2] = res_if.corrected_z;
            got.smth[0] = res_if.smoothed_x;
            got.smth[1] = res_if.smoothed_y;
            got.smth[2] = res_if.smoothed_z;
            got.tflag = res_if.timeout_seen;
            sb.check_word(got);
        end
    end

    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic apb_write(logic [2:0] idx, logic [63:0] v);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= v;
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_sample(logic cmd, logic [15:0] rx, logic [15:0] ry, logic [15:0] rz,
                               logic tout);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        smp_if.valid <= 1; smp_if.cmd <= cmd; smp_if.raw_x <= rx; smp_if.raw_y <= ry;
        smp_if.raw_z <= rz; smp_if.timed_out <= tout;
        do @(posedge i_clk); while (!smp_if.ready);
        sb.note_sample(cmd, rx, ry, rz, tout);
        n_sent++;
        smp_if.valid <= 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rnd_word();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(31)) - 16'd16;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [53:0] rnd_row(int j);
        logic [53:0] r;
        if ($urandom_range(3) == 0) return 54'({$urandom, $urandom});
        r = 0;
        for (int i = 0; i < 3; i++)
            r[18*i +: 18] = (i == j ? 18'd65536 : 18'd0) + 18'($urandom_range(8191)) - 18'd4096;
        return r;
    endfunction

    task automatic random_config(int mode);
        apb_write(imu_scf_pkg::REG_ACCEL_BIAS, mode == 0 ? 64'hffff_ffff_ffff_ffff :
                  mode == 1 ? 64'h0008_0000_8000_0800 : {$urandom, $urandom});
        apb_write(imu_scf_pkg::REG_MAG_BIAS, mode == 0 ? 64'h0007_ffff_7fff_f7ff :
                  mode == 1 ? 64'h0008_0000_8000_0800 : {$urandom, $urandom});
        apb_write(imu_scf_pkg::REG_ROW_X,
                  mode == 1 ? 64'h003f_fffe_0001_ffff : 64'(rnd_row(0)));
        apb_write(imu_scf_pkg::REG_ROW_Y,
                  mode == 1 ? 64'h0020_0002_0000_0000 : 64'(rnd_row(1)));
        apb_write(imu_scf_pkg::REG_ROW_Z,
                  mode == 1 ? 64'h001f_fffd_ffff_ffff : 64'(rnd_row(2)));
        apb_write(imu_scf_pkg::REG_ACCEL_SMOOTH, mode == 0 ? 64'd0 : mode == 1 ? 64'h1ffff :
                  64'($urandom_range(65536)));
        apb_write(imu_scf_pkg::REG_MAG_SMOOTH, mode == 0 ? 64'd65536 : mode == 1 ? 64'd65535 :
                  64'($urandom_range(65536)));
    endtask

    initial begin
        int idle_pct [4] = '{0, 53, 0, 21};
        int stall_pct [4] = '{0, 0, 53, 21};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        repeat (2) @(posedge i_clk);

        // reset settings first, including the first-sample load of both filters
        send_sample(0, 16'h7fff, 16'h8000, 16'h0001, 0);
        send_sample(1, 16'h8000, 16'h7fff, 16'hffff, 0);
        send_sample(0, 16'h8000, 16'h7fff, 16'h0000, 0);
        send_sample(1, 16'h7fff, 16'h8000, 16'h0000, 0);
        send_sample(0, 16'h1234, 16'h5678, 16'h9abc, 1);
        send_sample(1, 16'hffff, 16'hffff, 16'hffff, 1);
        send_sample(0, 16'h000f, 16'hfff1, 16'h0010, 0);
        send_sample(1, 16'h0000, 16'h0000, 16'h0000, 0);
        drain();
        for (int m = 0; m < 2; m++) begin
            random_config(m);
            for (int k = 0; k < 6; k++)
                send_sample(k[0], k < 2 ? 16'h8000 : 16'h7fff, k < 4 ? 16'h7fff : 16'h8000,
                            16'h8000, k == 5);
            drain();
        end

        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct = idle_pct[ph % 4];
            recv_stall_pct = stall_pct[ph % 4];
            random_config(ph == 7 ? 0 : 2);
            for (int k = 0; k < 175; k++)
                send_sample($urandom_range(1), rnd_word(), rnd_word(), rnd_word(),
                            $urandom_range(15) == 0);
            send_idle_pct = 0;
            recv_stall_pct = 0;
            drain();
        end

        $display("Covered %0d samples over %0d result words, ten register settings",
                 n_sent, sb.n_words);
        $display("plus extremes, timeouts and idle/stall phases on both channels.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_imu_sample_correct_filter: PASS");
        else
            $display("tb_imu_sample_correct_filter: FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_imu_sample_correct_filter: FAIL");
        $finish;
    end
endmodule

FILE: imu_sample_correct_filter.f
+incdir+rtl
rtl/imu_scf_pkg.sv
rtl/imu_scf_if.sv
rtl/imu_scf_lane.sv
rtl/imu_scf_merge.sv
rtl/imu_sample_correct_filter.sv
tb/tb_imu_sample_correct_filter.sv
